### hdl/utt_pkg.sv
// utt_pkg: shared types and constants of the utf-8 transcoder
// holds the queue entry type, target and error codes, and default sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package utt_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [2:0] TGT_UTF8    = 3'd0;
	localparam logic [2:0] TGT_ASCII   = 3'd1;
	localparam logic [2:0] TGT_LATIN1  = 3'd2;
	localparam logic [2:0] TGT_UTF16LE = 3'd3;
	localparam logic [2:0] TGT_UTF16BE = 3'd4;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_BAD_LEAD = 3'd1;
	localparam logic [2:0] ERR_TRUNC    = 3'd2;
	localparam logic [2:0] ERR_BAD_CONT = 3'd3;
	localparam logic [2:0] ERR_INVALID  = 3'd4;
	localparam logic [2:0] ERR_NOT_ENC  = 3'd5;

	// one queued item: up to four result bytes that share one error code
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      err;
		logic [1:0]      last_idx;
		logic            eos;
	} utt_job_t;

	// read side of the queue
	typedef struct packed {
		logic     valid;
		utt_job_t job;
	} utt_q_rd_t;

endpackage
`default_nettype wire

### hdl/utt_front.sv
// utt_front: accepts input bytes, decodes and validates utf-8 and encodes
// each completed code point, or an error, into a queue entry
// depends on utt_pkg
`timescale 1ns / 1ps
`default_nettype none
module utt_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        in_byte,
	input  wire logic              end_of_string,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_wdata,
	output utt_pkg::utt_job_t      push_job,
	output logic                   push
);

	logic [20:0] code_accum_q, acc_n;
	logic [1:0]  bytes_remaining_q, rem_n;
	logic [1:0]  sequence_length_q, len_n;
	logic        failed_q, failed_n;
	logic [2:0]  target_q;

	logic [20:0] cp_d;
	logic [1:0]  rem_d, len_d;
	logic [2:0]  dec_err;
	logic [2:0]  err;
	logic        complete;
	logic        enc_ok;
	logic [3:0][7:0] enc_data;
	logic [1:0]  enc_last;
	logic [15:0] unit0, unit1;
	logic [19:0] adj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_accum_q      <= '0;
			bytes_remaining_q <= '0;
			sequence_length_q <= '0;
			failed_q          <= 1'b0;
			target_q          <= utt_pkg::TGT_UTF8;
		end else begin
			code_accum_q      <= acc_n;
			bytes_remaining_q <= rem_n;
			sequence_length_q <= len_n;
			failed_q          <= failed_n;
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
		end
	end

	// decode the incoming byte against the open sequence
	always_comb begin
		cp_d    = code_accum_q;
		rem_d   = bytes_remaining_q;
		len_d   = sequence_length_q;
		dec_err = utt_pkg::ERR_NONE;
		if (bytes_remaining_q == 2'd0) begin
			priority if (in_byte[7] == 1'b0) begin
				cp_d  = {13'd0, in_byte};
				len_d = 2'd0;
			end else if (in_byte[7:5] == 3'b110) begin
				cp_d  = {16'd0, in_byte[4:0]};
				len_d = 2'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				cp_d  = {17'd0, in_byte[3:0]};
				len_d = 2'd2;
			end else if (in_byte[7:3] == 5'b11110) begin
				cp_d  = {18'd0, in_byte[2:0]};
				len_d = 2'd3;
			end else begin
				dec_err = utt_pkg::ERR_BAD_LEAD;
			end
			rem_d = len_d;
		end else if (in_byte[7:6] != 2'b10) begin
			dec_err = utt_pkg::ERR_BAD_CONT;
		end else begin
			cp_d  = {code_accum_q[14:0], in_byte[5:0]};
			rem_d = bytes_remaining_q - 2'd1;
		end
	end

	// encoder for the code point that the current byte completes
	always_comb begin
		enc_ok   = 1'b1;
		enc_data = '0;
		enc_last = 2'd0;
		adj      = cp_d[19:0] - 20'h10000;
		unit0    = cp_d[15:0];
		unit1    = '0;
		if (cp_d >= 21'h10000) begin
			unit0 = {6'b110110, adj[19:10]};
			unit1 = {6'b110111, adj[9:0]};
		end
		unique case (target_q)
			utt_pkg::TGT_UTF8: begin
				if (cp_d < 21'h80) begin
					enc_data[0] = cp_d[7:0];
				end else if (cp_d < 21'h800) begin
					enc_data[0] = {3'b110, cp_d[10:6]};
					enc_data[1] = {2'b10, cp_d[5:0]};
					enc_last    = 2'd1;
				end else if (cp_d < 21'h10000) begin
					enc_data[0] = {4'b1110, cp_d[15:12]};
					enc_data[1] = {2'b10, cp_d[11:6]};
					enc_data[2] = {2'b10, cp_d[5:0]};
					enc_last    = 2'd2;
				end else begin
					enc_data[0] = {5'b11110, cp_d[20:18]};
					enc_data[1] = {2'b10, cp_d[17:12]};
					enc_data[2] = {2'b10, cp_d[11:6]};
					enc_data[3] = {2'b10, cp_d[5:0]};
					enc_last    = 2'd3;
				end
			end
			utt_pkg::TGT_ASCII: begin
				enc_ok      = (cp_d < 21'h80);
				enc_data[0] = cp_d[7:0];
			end
			utt_pkg::TGT_LATIN1: begin
				enc_ok      = (cp_d < 21'h100);
				enc_data[0] = cp_d[7:0];
			end
			utt_pkg::TGT_UTF16LE: begin
				enc_data = {unit1[15:8], unit1[7:0], unit0[15:8], unit0[7:0]};
				enc_last = (cp_d >= 21'h10000) ? 2'd3 : 2'd1;
			end
			utt_pkg::TGT_UTF16BE: begin
				enc_data = {unit1[7:0], unit1[15:8], unit0[7:0], unit0[15:8]};
				enc_last = (cp_d >= 21'h10000) ? 2'd3 : 2'd1;
			end
			default: begin
				enc_ok = 1'b0;
			end
		endcase
	end

	// validate and build the queue entry
	always_comb begin
		acc_n    = code_accum_q;
		rem_n    = bytes_remaining_q;
		len_n    = sequence_length_q;
		failed_n = failed_q;
		err      = utt_pkg::ERR_NONE;
		complete = 1'b0;
		push     = 1'b0;
		push_job = '0;
		if (accept) begin
			if (failed_q) begin
				if (end_of_string) begin
					failed_n = 1'b0;
					acc_n    = '0;
					rem_n    = '0;
					len_n    = '0;
				end
			end else begin
				acc_n = cp_d;
				rem_n = rem_d;
				len_n = len_d;
				err   = dec_err;
				if (err == utt_pkg::ERR_NONE) begin
					if (rem_d != 2'd0) begin
						if (end_of_string) begin
							err = utt_pkg::ERR_TRUNC;
						end
					end else begin
						complete = 1'b1;
						if ((len_d == 2'd1 && cp_d < 21'h80) ||
							(len_d == 2'd2 && cp_d < 21'h800) ||
							(len_d == 2'd3 && cp_d < 21'h10000) ||
							(cp_d >= 21'hD800 && cp_d <= 21'hDFFF) ||
							cp_d > 21'h10FFFF) begin
							err = utt_pkg::ERR_INVALID;
						end else if (!enc_ok) begin
							err = utt_pkg::ERR_NOT_ENC;
						end
					end
				end
				push_job.eos = end_of_string;
				if (err != utt_pkg::ERR_NONE) begin
					push         = 1'b1;
					push_job.err = err;
					failed_n     = !end_of_string;
				end else if (complete) begin
					push              = 1'b1;
					push_job.data     = enc_data;
					push_job.last_idx = enc_last;
				end
				if (err != utt_pkg::ERR_NONE || complete || end_of_string) begin
					acc_n = '0;
					rem_n = '0;
					len_n = '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

### hdl/utt_fifo.sv
// utt_fifo: short queue of encoded items between front and back end
// depends on utt_pkg
`timescale 1ns / 1ps
`default_nettype none
module utt_fifo #(
	parameter int unsigned DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  utt_pkg::utt_job_t      push_job,
	input  wire logic              pop,
	output utt_pkg::utt_q_rd_t     rd,
	output logic                   full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	utt_pkg::utt_job_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign do_push = push && !full;
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd.valid = (count_q != '0);
	assign rd.job   = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

### hdl/utt_back.sv
// utt_back: walks the bytes of the queue head into the output register
// depends on utt_pkg
`timescale 1ns / 1ps
`default_nettype none
module utt_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  utt_pkg::utt_q_rd_t     rd,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic [2:0]             error,
	output logic                   last_of_run,
	output logic                   string_done
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [2:0] err_q;
	logic       last_q, done_q;
	logic       load, at_last;

	assign load    = !valid_q || out_ready;
	assign at_last = (idx_q == rd.job.last_idx);
	assign pop     = load && rd.valid && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= rd.valid;
			if (rd.valid) begin
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && rd.valid) begin
			byte_q <= rd.job.data[idx_q];
			err_q  <= rd.job.err;
			last_q <= at_last;
			done_q <= at_last && rd.job.eos;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign error       = err_q;
	assign last_of_run = last_q;
	assign string_done = done_q;

endmodule
`default_nettype wire

### hdl/utt_core_top.sv
// utf8_to_target_transcoder_core: top level of the utf-8 transcoder
// instantiates utt_front, utt_fifo and utt_back; depends on utt_pkg
`timescale 1ns / 1ps
`default_nettype none
// The block takes one utf-8 byte per cycle while its queue has room and
// hands out one result byte per cycle, while out_ready is high, through a
// registered output. A byte that finishes a code point gives one to four
// result bytes, walked out through the single output byte register; bytes
// that complete nothing push no queue entry and take no back-end time, so
// the sustained input rate is one byte per cycle for utf-8 to utf-8, while
// ascii to utf-16 is held back by the output. Errors give a single result
// with out_byte zero; the string then stays silent up to its last byte.
module utf8_to_target_transcoder_core #(
	parameter int unsigned QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_string,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic [2:0]      error,
	output logic            last_of_run,
	output logic            string_done,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata
);

	utt_pkg::utt_job_t  push_job;
	utt_pkg::utt_q_rd_t q_rd;
	logic               push, pop, q_full, in_accept;

	assign in_ready  = !q_full;
	assign in_accept = in_valid && in_ready;

	utt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.push_job      (push_job),
		.push          (push)
	);

	utt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.rd       (q_rd),
		.full     (q_full)
	);

	utt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd          (q_rd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.error       (error),
		.last_of_run (last_of_run),
		.string_done (string_done)
	);

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_done) |-> last_of_run)
		else $error("string_done on a result that is not last of its run");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error != utt_pkg::ERR_NONE) |-> (last_of_run && out_byte == 8'd0))
		else $error("error result is not a single zero byte");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=> out_valid)
		else $error("run of result bytes broken off");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (in_accept && !q_full))
		else $error("queue written without an accepted item or while full");

endmodule
`default_nettype wire
